[hw/rtl/link_request_from_load_assert.svh]
// Assertion macros shared by the link request checker.
// Needs nothing else; include by bare file name.
`ifndef LINK_REQUEST_FROM_LOAD_ASSERT_SVH
`define LINK_REQUEST_FROM_LOAD_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define LRFL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define LRFL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lrfl_pkg.sv]
// Shared types, widths and constants of the link request block.
// No dependencies; every module file imports it.
`default_nettype none

package lrfl_pkg;

  localparam int LOAD_W   = 16;
  localparam int THRESH_W = 16;
  localparam int DIST_W   = 24;
  localparam int SEC_W    = 16;
  localparam int CODE_W   = 8;
  localparam int CASE_W   = 3;
  localparam int PROD_W   = 28;  // threshold * 3600 fits below 2**28
  localparam int DEN_W    = 15;  // positive load magnitude
  localparam int TIME_W   = 24;  // time after the range check
  localparam int FRAME_W  = 5;
  localparam int LINK_W   = 3;
  localparam int HOUR_W   = 12;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [HOUR_W-1:0]  SECONDS_PER_HOUR = 12'd3600;
  localparam logic [FRAME_W-1:0] FRAME_DELTA_MAX  = 5'd31;
  localparam logic [FRAME_W-1:0] FRAME_DELTA_ONE  = 5'd1;
  localparam logic [LINK_W-1:0]  LINK_COUNT_MIN   = 3'd1;
  localparam logic [LINK_W-1:0]  LINK_COUNT_MAX   = 3'd7;
  localparam logic [LINK_W:0]    LINK_BASE        = 4'd8;

  localparam logic [THRESH_W-1:0] RST_MSG_THRESHOLD = 16'd10;
  localparam logic [DIST_W-1:0]   RST_MAX_DIST      = 24'd3968;
  localparam logic [SEC_W-1:0]    RST_FRAME_SEC     = 16'd128;
  localparam logic [SEC_W-1:0]    RST_MIN_DIST      = 16'd16;
  localparam logic [CODE_W-1:0]   RST_MAX_CODE      = 8'd249;
  localparam logic [CODE_W-1:0]   RST_MIN_CODE      = 8'd15;

  typedef enum logic [2:0] {
    REG_MSG_THRESHOLD = 3'd0,
    REG_MAX_DIST      = 3'd1,
    REG_FRAME_SEC     = 3'd2,
    REG_MIN_DIST      = 3'd3,
    REG_MAX_CODE      = 3'd4,
    REG_MIN_CODE      = 3'd5
  } lrfl_reg_e;

  typedef enum logic [CASE_W-1:0] {
    CASE_NONPOS     = 3'd0,
    CASE_BEYOND_MAX = 3'd1,
    CASE_FRAMES     = 3'd2,
    CASE_MINIMUM    = 3'd3,
    CASE_SUBFRAME   = 3'd4
  } lrfl_case_e;

  // One classified beat from the front end.
  typedef struct packed {
    logic              nonpos;
    logic [PROD_W-1:0] num;
    logic [DEN_W-1:0]  den;
  } lrfl_job_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [DIST_W-1:0] max_dist;
    logic [SEC_W-1:0]  frame_sec;
    logic [SEC_W-1:0]  min_dist;
    logic [CODE_W-1:0] max_code;
    logic [CODE_W-1:0] min_code;
  } lrfl_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/lrfl_front.sv]
// Front end: accepts loads, flags nonpositive ones, forms threshold * 3600.
// Depends on lrfl_pkg.
`default_nettype none

module lrfl_front import lrfl_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [LOAD_W-1:0]      system_load_i,
  input  logic [THRESH_W-1:0]           threshold_i,
  input  logic [$clog2(QueueDepth+1)-1:0] queue_count_i,
  output logic                          push_o,
  output lrfl_job_t                     job_o
);

  localparam int CntW = $clog2(QueueDepth + 1);

  logic                     s1_v_q;
  logic signed [LOAD_W-1:0] s1_load_q;
  logic                     s2_v_q;
  lrfl_job_t                s2_job_q;
  logic [CntW:0]            occupancy;
  logic                     accept;

  // Count every beat that will land in the queue and hold off when full.
  assign occupancy = (CntW+1)'(queue_count_i) + (CntW+1)'(s1_v_q) + (CntW+1)'(s2_v_q);
  assign busy      = occupancy >= (CntW+1)'(QueueDepth);
  assign accept    = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_load_q <= system_load_i;
    end
    if (s1_v_q) begin
      s2_job_q.nonpos <= s1_load_q <= 0;
      s2_job_q.num    <= PROD_W'(threshold_i) * PROD_W'(SECONDS_PER_HOUR);
      s2_job_q.den    <= s1_load_q[DEN_W-1:0];
    end
  end

  assign push_o = s2_v_q;
  assign job_o  = s2_job_q;

endmodule

`default_nettype wire

[hw/rtl/lrfl_queue.sv]
// Small FIFO that decouples the front end from the back end.
// Depends on lrfl_pkg for the beat type.
`default_nettype none

module lrfl_queue import lrfl_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  lrfl_job_t                  job_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output lrfl_job_t                  job_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  lrfl_job_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q;
  logic [PtrW-1:0]     rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign valid_o = count_q != '0;
  assign job_o   = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push_i) - CntW'(do_pop);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lrfl_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Quotient is exact when num < den * 2**QuoW. Depends on lrfl_pkg.
`default_nettype none

module lrfl_div import lrfl_pkg::*; #(
  parameter int NumW = PROD_W,
  parameter int DenW = DEN_W,
  parameter int QuoW = PROD_W,
  parameter int TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [QuoW-1:0] quo_o,
  output logic [TagW-1:0] tag_o
);

  localparam int WideW = NumW + DenW;

  logic            v_q   [QuoW];
  logic [NumW-1:0] rem_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [TagW-1:0] tag_q [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    localparam int Bit = QuoW - 1 - s;

    logic             v_in;
    logic [NumW-1:0]  rem_in;
    logic [QuoW-1:0]  quo_in;
    logic [DenW-1:0]  den_in;
    logic [TagW-1:0]  tag_in;
    logic [WideW-1:0] shifted;
    logic             take;
    logic [QuoW-1:0]  quo_d;
    logic [NumW-1:0]  rem_d;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    // Try subtracting the divisor at this bit's weight.
    assign shifted = WideW'(den_in) << Bit;
    assign take    = WideW'(rem_in) >= shifted;
    assign rem_d   = take ? NumW'(WideW'(rem_in) - shifted) : rem_in;

    always_comb begin
      quo_d      = quo_in;
      quo_d[Bit] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      quo_q[s] <= quo_d;
      den_q[s] <= den_in;
      tag_q[s] <= tag_in;
    end
  end

  assign valid_o = v_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];
  assign tag_o   = tag_q[QuoW-1];

endmodule

`default_nettype wire

[hw/rtl/lrfl_back.sv]
// Back end: time-to-threshold division, range classification, frame or
// link division and request packing. Depends on lrfl_pkg and lrfl_div.
`default_nettype none

module lrfl_back import lrfl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  lrfl_job_t         job_i,
  input  lrfl_cfg_t         cfg_i,
  output logic              done_o,
  output logic [CODE_W-1:0] link_request_o,
  output logic [CASE_W-1:0] decision_case_o
);

  localparam int SmTagW = CASE_W + 1;

  // Time to threshold.
  logic              t_v;
  logic [PROD_W-1:0] t_val;
  logic              t_nonpos;

  lrfl_div #(
    .NumW(PROD_W),
    .DenW(DEN_W),
    .QuoW(PROD_W),
    .TagW(1)
  ) u_time_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .num_i   (job_i.num),
    .den_i   (job_i.den),
    .tag_i   (job_i.nonpos),
    .valid_o (t_v),
    .quo_o   (t_val),
    .tag_o   (t_nonpos)
  );

  // Classify against the configured distances.
  logic              beyond, ge_frame, le_min, sat_frame, sat_min;
  lrfl_case_e        cls_case_d;
  logic              cls_v_q;
  lrfl_case_e        cls_case_q;
  logic [TIME_W-1:0] cls_t_q;
  logic [SEC_W-1:0]  cls_den_q;
  logic              cls_sat_q;

  assign beyond    = t_val > PROD_W'(cfg_i.max_dist);
  assign ge_frame  = t_val >= PROD_W'(cfg_i.frame_sec);
  assign le_min    = t_val <= PROD_W'(cfg_i.min_dist);
  assign sat_frame = t_val >= (PROD_W'(cfg_i.frame_sec) << FRAME_W);
  assign sat_min   = t_val >= (PROD_W'(cfg_i.min_dist) << FRAME_W);

  always_comb begin
    if (t_nonpos) begin
      cls_case_d = CASE_NONPOS;
    end else if (beyond) begin
      cls_case_d = CASE_BEYOND_MAX;
    end else if (ge_frame) begin
      cls_case_d = CASE_FRAMES;
    end else if (le_min) begin
      cls_case_d = CASE_MINIMUM;
    end else begin
      cls_case_d = CASE_SUBFRAME;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_v_q <= 1'b0;
    end else begin
      cls_v_q <= t_v;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_case_q <= cls_case_d;
    cls_t_q    <= t_val[TIME_W-1:0];
    cls_den_q  <= (cls_case_d == CASE_FRAMES) ? cfg_i.frame_sec : cfg_i.min_dist;
    cls_sat_q  <= (cls_case_d == CASE_FRAMES) ? sat_frame : sat_min;
  end

  // Short division, quotient saturated at five bits.
  logic              sm_v;
  logic [FRAME_W-1:0] sm_quo;
  logic [SmTagW-1:0] sm_tag;
  lrfl_case_e        sm_case;
  logic [FRAME_W-1:0] quo_sat;
  logic [LINK_W-1:0] links;
  logic [CODE_W-1:0] req_d;

  lrfl_div #(
    .NumW(TIME_W),
    .DenW(SEC_W),
    .QuoW(FRAME_W),
    .TagW(SmTagW)
  ) u_frame_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cls_v_q),
    .num_i   (cls_t_q),
    .den_i   (cls_den_q),
    .tag_i   ({cls_case_q, cls_sat_q}),
    .valid_o (sm_v),
    .quo_o   (sm_quo),
    .tag_o   (sm_tag)
  );

  assign sm_case = lrfl_case_e'(sm_tag[SmTagW-1:1]);
  assign quo_sat = sm_tag[0] ? FRAME_DELTA_MAX : sm_quo;

  always_comb begin
    if (quo_sat >= FRAME_W'(LINK_BASE - LINK_W'(LINK_COUNT_MIN))) begin
      links = LINK_COUNT_MIN;
    end else if (quo_sat == '0) begin
      links = LINK_COUNT_MAX;
    end else begin
      links = LINK_W'(LINK_BASE - (LINK_W+1)'(quo_sat[LINK_W-1:0]));
    end
  end

  always_comb begin
    unique case (sm_case)
      CASE_FRAMES:   req_d = {quo_sat, LINK_COUNT_MIN};
      CASE_SUBFRAME: req_d = {FRAME_DELTA_ONE, links};
      CASE_MINIMUM:  req_d = cfg_i.min_code;
      default:       req_d = cfg_i.max_code;
    endcase
  end

  logic              done_q;
  logic [CODE_W-1:0] req_q;
  logic [CASE_W-1:0] case_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sm_v;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    case_q <= sm_case;
  end

  assign done_o          = done_q;
  assign link_request_o  = req_q;
  assign decision_case_o = case_q;

endmodule

`default_nettype wire

[hw/rtl/link_request_from_load.sv]
// Top level of the link request block: register file, front end, queue, back end.
// Depends on lrfl_pkg, lrfl_front, lrfl_queue, lrfl_div and lrfl_back.
//
// Usage:
// - Input channel: drive system_load_i and raise start; the beat is taken at
//   a rising edge where start is high and busy is low.
// - Result channel: done_o pulses for one cycle per beat with link_request_o
//   and decision_case_o. The receiver cannot hold results off; take them as
//   they come, one per done_o cycle, in input order.
// - Path: from the accepting edge a beat passes two front stages (load
//   register, threshold * 3600 product), one queue slot, 28 stages of the
//   time divider, one classify stage, five stages of the frame or link
//   divider and the output register, which drives done_o.
// - Throughput: one beat per cycle. Each divider retires one quotient bit per
//   stage, so every stage holds a different beat. busy rises only if the
//   queue and front stages together would overflow the queue, which the back
//   end, draining a beat every cycle, does not let happen at the default depth.
// - Configuration: APB writes at byte address 4*i for the six registers;
//   write only while no beat is in flight. pready is tied high.
// - Reset: clears all valid flags and the queue and loads the register
//   defaults; no clearing pass is needed.
`default_nettype none

module link_request_from_load import lrfl_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input beats
  input  logic                     start,
  output logic                     busy,
  input  logic signed [LOAD_W-1:0] system_load_i,
  // result beats
  output logic                     done_o,
  output logic [CODE_W-1:0]        link_request_o,
  output logic [CASE_W-1:0]        decision_case_o,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int CntW = $clog2(QueueDepth + 1);

  // Register file.
  logic [THRESH_W-1:0] msg_threshold_q;
  lrfl_cfg_t           cfg_q;
  logic                wr_en;
  lrfl_reg_e           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = lrfl_reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_threshold_q <= RST_MSG_THRESHOLD;
      cfg_q.max_dist  <= RST_MAX_DIST;
      cfg_q.frame_sec <= RST_FRAME_SEC;
      cfg_q.min_dist  <= RST_MIN_DIST;
      cfg_q.max_code  <= RST_MAX_CODE;
      cfg_q.min_code  <= RST_MIN_CODE;
    end else if (wr_en) begin
      // Drop writes past the last register and bits above each width.
      unique case (reg_idx)
        REG_MSG_THRESHOLD: msg_threshold_q <= pwdata[THRESH_W-1:0];
        REG_MAX_DIST:      cfg_q.max_dist  <= pwdata[DIST_W-1:0];
        REG_FRAME_SEC:     cfg_q.frame_sec <= pwdata[SEC_W-1:0];
        REG_MIN_DIST:      cfg_q.min_dist  <= pwdata[SEC_W-1:0];
        REG_MAX_CODE:      cfg_q.max_code  <= pwdata[CODE_W-1:0];
        REG_MIN_CODE:      cfg_q.min_code  <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MSG_THRESHOLD: prdata = DATA_W'(msg_threshold_q);
      REG_MAX_DIST:      prdata = DATA_W'(cfg_q.max_dist);
      REG_FRAME_SEC:     prdata = DATA_W'(cfg_q.frame_sec);
      REG_MIN_DIST:      prdata = DATA_W'(cfg_q.min_dist);
      REG_MAX_CODE:      prdata = DATA_W'(cfg_q.max_code);
      REG_MIN_CODE:      prdata = DATA_W'(cfg_q.min_code);
      default:           prdata = '0;
    endcase
  end

  // Front end and queue: accept, flag nonpositive loads, buffer.
  logic            push;
  lrfl_job_t       push_job;
  logic [CntW-1:0] queue_count;
  logic            queue_valid;
  lrfl_job_t       queue_job;

  lrfl_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .system_load_i (system_load_i),
    .threshold_i   (msg_threshold_q),
    .queue_count_i (queue_count),
    .push_o        (push),
    .job_o         (push_job)
  );

  lrfl_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (queue_valid),
    .valid_o (queue_valid),
    .job_o   (queue_job),
    .count_o (queue_count)
  );

  // Back end: drain one beat every cycle the queue holds one.
  lrfl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (queue_valid),
    .job_i           (queue_job),
    .cfg_i           (cfg_q),
    .done_o          (done_o),
    .link_request_o  (link_request_o),
    .decision_case_o (decision_case_o)
  );

endmodule

`default_nettype wire

[hw/rtl/lrfl_checker.sv]
// Port-level checks for the link request block, bound to its top level.
// Depends on lrfl_pkg and link_request_from_load_assert.svh.
`default_nettype none
`include "link_request_from_load_assert.svh"

module lrfl_checker import lrfl_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              pready,
  input logic              done_o,
  input logic [CODE_W-1:0] link_request_o,
  input logic [CASE_W-1:0] decision_case_o
);

  `LRFL_ASSERT_ALWAYS(a_pready_high, clk_i, rst_ni, pready, "pready dropped")

  // Frame requests carry one link and at least one frame.
  `LRFL_ASSERT_IMPLY(a_frames_packing, clk_i, rst_ni, done_o && decision_case_o == CASE_FRAMES, link_request_o[LINK_W-1:0] == LINK_COUNT_MIN && link_request_o[CODE_W-1:LINK_W] != '0, "bad frame request packing")

  // Sub-frame requests carry one frame and a nonzero link count.
  `LRFL_ASSERT_IMPLY(a_subframe_packing, clk_i, rst_ni, done_o && decision_case_o == CASE_SUBFRAME, link_request_o[CODE_W-1:LINK_W] == FRAME_DELTA_ONE && link_request_o[LINK_W-1:0] != '0, "bad sub-frame request packing")

endmodule

bind link_request_from_load lrfl_checker u_lrfl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready          (pready),
  .done_o          (done_o),
  .link_request_o  (link_request_o),
  .decision_case_o (decision_case_o)
);

`default_nettype wire
